// ----- rtl/ecc_pkg.sv -----
// ============================================================================
// ecc_pkg
// Types and constants shared by the edge corner classifier.
// ============================================================================
`default_nettype none
package ecc_pkg;

   localparam int MAX_POINTS       = 128;
   localparam int IDX_W            = $clog2(MAX_POINTS);
   localparam int CNT_W            = IDX_W + 1;
   localparam int SPREAD_LOOKAHEAD = 50;

   // Angle thresholds in Q3.12, doubled to match twice the strength.
   localparam logic signed [17:0] TH2_Y_LO = 18'sd4290;
   localparam logic signed [17:0] TH2_Y_HI = 18'sd9294;
   localparam logic signed [17:0] TH2_L_LO = 18'sd10008;
   localparam logic signed [17:0] TH2_L_HI = 18'sd20016;
   localparam logic signed [17:0] TH2_BEND = 18'sd714;

   localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
   localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] OP_EVALUATE   = 2'd2;

   localparam logic [2:0] CSR_OFFSET    = 3'd0;
   localparam logic [2:0] CSR_CORNER    = 3'd1;
   localparam logic [2:0] CSR_STRAIGHT  = 3'd2;
   localparam logic [2:0] CSR_PPM       = 3'd3;
   localparam logic [2:0] CSR_CHECK_L   = 3'd4;

   typedef struct packed {
      logic signed [14:0] x;
      logic signed [14:0] y;
      logic signed [14:0] a;
      logic               keep;
   } point_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SC_CEN,    // read center point
      ST_SC_LO,     // read low neighbour
      ST_SC_HI,     // read high neighbour
      ST_SC_EVAL,   // compute strength
      ST_SC_TEST,   // compare and update
      ST_PAIR_SEL,  // pick the pair checks from the final corner flags
      ST_PAIR_RD,   // read corner points of pair
      ST_PAIR_W,    // read lookahead points
      ST_PAIR_D0,   // coordinate differences
      ST_PAIR_D1,   // squares
      ST_PAIR_D2,   // sum (corner pair), square of lookahead dist
      ST_PAIR_D3,   // scale by 25 (corner pair), lookahead sum
      ST_PAIR_D4,   // compare (corner pair)
      ST_PAIR_D5,   // scale and compare
      ST_DONE
   } state_type;

   typedef struct packed {
      logic scan_init;
      logic scan_side;     // 0 left, 1 right
      logic rd_cen;
      logic rd_lo;
      logic rd_hi;
      logic eval;
      logic test;
      logic scan_next;
      logic pair_l;        // 1 when checking the L pair
      logic rd_pair;
      logic rd_look;
      logic d0;
      logic d1;
      logic d2;
      logic d3;
      logic d4;
      logic d5;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic y_pair_needed;
      logic l_pair_needed;
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/edge_corner_classifier.sv -----
// ============================================================================
// edge_corner_classifier
// Y and L corner finder over the left and right edge curves.
// ============================================================================
// Usage: req_opcode selects a beat type. A load beat (left or right) writes
// one point into that side's store, so loads can follow back to back; loads
// past the store depth are dropped. An evaluate beat scans the left then the
// right curve, one pass of center, low, high, eval and test steps per stored
// point (an empty side takes one pass as if it held one point), spends a step
// choosing the pair checks, runs up to two pair checks and ends with
// one result beat on the rsp_ ports, rsp_valid high for a single cycle.
// The result beat comes in the last cycle that busy is high; a new start is
// taken in the cycle after it. Loads and unknown opcodes never raise busy and
// give no result. After an evaluate both point counts are zero again.
// Reset is synchronous: counts clear and registers return to their defaults;
// the point stores are not cleared. The receiver cannot stall: rsp_valid is
// a one-cycle strobe. Registers must be written via csr_ only while idle;
// the block itself does not enforce it.
`default_nettype none
module edge_corner_classifier
   import ecc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [14:0] req_point_x,
   input  wire logic signed [14:0] req_point_y,
   input  wire logic signed [14:0] req_angle_change,
   input  wire logic               req_suppressed_keep,
   output logic                    rsp_valid,
   output logic                    rsp_y_left_found,
   output logic [6:0]              rsp_y_left_index,
   output logic                    rsp_y_right_found,
   output logic [6:0]              rsp_y_right_index,
   output logic                    rsp_l_left_found,
   output logic [6:0]              rsp_l_left_index,
   output logic                    rsp_l_right_found,
   output logic [6:0]              rsp_l_right_index,
   output logic                    rsp_straight_left,
   output logic                    rsp_straight_right,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [7:0]         csr_data
);

   logic [5:0] offset_ff;
   logic [7:0] corner_ff, straight_ff, ppm_ff;
   logic       check_l_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= 6'd5;
         corner_ff   <= 8'd40;
         straight_ff <= 8'd50;
         ppm_ff      <= 8'd100;
         check_l_ff  <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OFFSET:   offset_ff   <= csr_data[5:0];
            CSR_CORNER:   corner_ff   <= csr_data;
            CSR_STRAIGHT: straight_ff <= csr_data;
            CSR_PPM:      ppm_ff      <= csr_data;
            CSR_CHECK_L:  check_l_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic       accept, go, load_en;
   cmd_type    cmd;
   status_type status;
   point_type  load_pt;

   assign accept  = start && !busy;
   assign go      = accept && (req_opcode == OP_EVALUATE);
   assign load_en = accept && (req_opcode == OP_LOAD_LEFT || req_opcode == OP_LOAD_RIGHT);
   assign load_pt = '{x: req_point_x, y: req_point_y, a: req_angle_change,
                      keep: req_suppressed_keep};

   ecc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ecc_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .load_en        (load_en),
      .load_side      (req_opcode[0]),
      .load_pt        (load_pt),
      .cmd            (cmd),
      .status         (status),
      .cfg_offset     (offset_ff),
      .cfg_corner     (corner_ff),
      .cfg_straight   (straight_ff),
      .cfg_ppm        (ppm_ff),
      .cfg_check_l    (check_l_ff),
      .y_left_found   (rsp_y_left_found),
      .y_left_index   (rsp_y_left_index),
      .y_right_found  (rsp_y_right_found),
      .y_right_index  (rsp_y_right_index),
      .l_left_found   (rsp_l_left_found),
      .l_left_index   (rsp_l_left_index),
      .l_right_found  (rsp_l_right_found),
      .l_right_index  (rsp_l_right_index),
      .straight_left  (rsp_straight_left),
      .straight_right (rsp_straight_right)
   );

   assign rsp_valid = cmd.finish;

endmodule
`default_nettype wire

// ----- rtl/ecc_ctrl.sv -----
// ============================================================================
// ecc_ctrl
// Sequencer for the evaluate command: scans both sides, then pair checks.
// ============================================================================
`default_nettype none
module ecc_ctrl
   import ecc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       go,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   state_type state_ff, state_in;
   logic      side_ff, side_in;
   logic      pl_ff, pl_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff  <= 1'b0;
         pl_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         pl_ff    <= pl_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      pl_in    = pl_ff;
      unique case (state_ff)
         ST_IDLE: begin
            side_in = 1'b0;
            if (go) state_in = ST_SC_CEN;
         end
         ST_SC_CEN:  state_in = ST_SC_LO;
         ST_SC_LO:   state_in = ST_SC_HI;
         ST_SC_HI:   state_in = ST_SC_EVAL;
         ST_SC_EVAL: state_in = ST_SC_TEST;
         ST_SC_TEST: begin
            if (!status.scan_last) begin
               state_in = ST_SC_CEN;
            end else if (!side_ff) begin
               side_in  = 1'b1;
               state_in = ST_SC_CEN;
            end else begin
               state_in = ST_PAIR_SEL;
            end
         end
         // The last scan step updates the corner flags at its own edge, so the
         // pair decision waits for them in a state of its own.
         ST_PAIR_SEL: begin
            if (status.y_pair_needed) begin
               pl_in    = 1'b0;
               state_in = ST_PAIR_RD;
            end else if (status.l_pair_needed) begin
               pl_in    = 1'b1;
               state_in = ST_PAIR_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PAIR_RD: state_in = ST_PAIR_W;
         ST_PAIR_W:  state_in = ST_PAIR_D0;
         ST_PAIR_D0: state_in = ST_PAIR_D1;
         ST_PAIR_D1: state_in = ST_PAIR_D2;
         ST_PAIR_D2: state_in = ST_PAIR_D3;
         ST_PAIR_D3: state_in = ST_PAIR_D4;
         ST_PAIR_D4: state_in = ST_PAIR_D5;
         ST_PAIR_D5: begin
            if (!pl_ff && status.l_pair_needed) begin
               pl_in    = 1'b1;
               state_in = ST_PAIR_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.scan_side = side_ff;
      cmd.pair_l    = pl_ff;
      unique case (state_ff)
         ST_IDLE:    cmd.scan_init = go;
         ST_SC_CEN:  cmd.rd_cen = 1'b1;
         ST_SC_LO:   cmd.rd_lo = 1'b1;
         ST_SC_HI:   cmd.rd_hi = 1'b1;
         ST_SC_EVAL: cmd.eval = 1'b1;
         ST_SC_TEST: begin
            cmd.test      = 1'b1;
            cmd.scan_next = 1'b1;
         end
         ST_PAIR_SEL: ;
         ST_PAIR_RD: cmd.rd_pair = 1'b1;
         ST_PAIR_W:  cmd.rd_look = 1'b1;
         ST_PAIR_D0: cmd.d0 = 1'b1;
         ST_PAIR_D1: cmd.d1 = 1'b1;
         ST_PAIR_D2: cmd.d2 = 1'b1;
         ST_PAIR_D3: cmd.d3 = 1'b1;
         ST_PAIR_D4: cmd.d4 = 1'b1;
         ST_PAIR_D5: cmd.d5 = 1'b1;
         ST_DONE:    cmd.finish = 1'b1;
         default:    cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && go) |=> (state_ff == ST_SC_CEN))
      else $error("evaluate did not start a scan");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_IDLE))
      else $error("done not followed by idle");
   a_pair_chain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAIR_RD) |=> (state_ff == ST_PAIR_W))
      else $error("pair read sequence broken");

endmodule
`default_nettype wire

// ----- rtl/ecc_datapath.sv -----
// ============================================================================
// ecc_datapath
// Point stores, scan arithmetic and pair distance checks.
// ============================================================================
`default_nettype none
module ecc_datapath
   import ecc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_en,
   input  wire logic              load_side,
   input  wire point_type         load_pt,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic [5:0]        cfg_offset,
   input  wire logic [7:0]        cfg_corner,
   input  wire logic [7:0]        cfg_straight,
   input  wire logic [7:0]        cfg_ppm,
   input  wire logic              cfg_check_l,
   output logic                   y_left_found,
   output logic [6:0]             y_left_index,
   output logic                   y_right_found,
   output logic [6:0]             y_right_index,
   output logic                   l_left_found,
   output logic [6:0]             l_left_index,
   output logic                   l_right_found,
   output logic [6:0]             l_right_index,
   output logic                   straight_left,
   output logic                   straight_right
);

   point_type left_mem [MAX_POINTS];
   point_type right_mem [MAX_POINTS];

   logic [CNT_W-1:0] lcnt_ff, rcnt_ff;

   // Read address per memory, chosen by the current step.
   logic [IDX_W-1:0] laddr, raddr;
   point_type        lrd_ff, rrd_ff;

   always_ff @(posedge clock) begin
      if (load_en && !load_side && lcnt_ff < CNT_W'(MAX_POINTS))
         left_mem[lcnt_ff[IDX_W-1:0]] <= load_pt;
      if (load_en && load_side && rcnt_ff < CNT_W'(MAX_POINTS))
         right_mem[rcnt_ff[IDX_W-1:0]] <= load_pt;
      lrd_ff <= left_mem[laddr];
      rrd_ff <= right_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcnt_ff <= '0;
         rcnt_ff <= '0;
      end else if (cmd.finish) begin
         lcnt_ff <= '0;
         rcnt_ff <= '0;
      end else if (load_en) begin
         if (!load_side && lcnt_ff < CNT_W'(MAX_POINTS)) lcnt_ff <= lcnt_ff + 1'b1;
         if (load_side && rcnt_ff < CNT_W'(MAX_POINTS)) rcnt_ff <= rcnt_ff + 1'b1;
      end
   end

   // ---------------- scan ----------------
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] n_cur;
   logic             empty_side;
   logic signed [CNT_W+1:0] lo_raw, hi_raw;
   logic [IDX_W-1:0] lo_idx, hi_idx;
   point_type        cur_rd;
   logic [14:0]      abs_rd;
   logic [14:0]      a_cen_ff, a_lo_ff;
   logic             keep_ff;
   logic signed [17:0] c2_ff;

   assign n_cur      = cmd.scan_side ? rcnt_ff : lcnt_ff;
   assign empty_side = (n_cur == '0);
   assign lo_raw     = $signed({2'b00, idx_ff}) - $signed({{(CNT_W-4){1'b0}}, cfg_offset});
   assign hi_raw     = $signed({2'b00, idx_ff}) + $signed({{(CNT_W-4){1'b0}}, cfg_offset});
   assign lo_idx     = lo_raw[CNT_W+1] ? '0 : lo_raw[IDX_W-1:0];
   assign hi_idx     = (hi_raw >= $signed({2'b00, n_cur})) ?
                       IDX_W'(n_cur - 1'b1) : hi_raw[IDX_W-1:0];
   assign cur_rd     = cmd.scan_side ? rrd_ff : lrd_ff;
   assign abs_rd     = cur_rd.a[14] ? 15'(-cur_rd.a) : 15'(cur_rd.a);

   // Pair bookkeeping.
   logic             y_f_ff [2], l_f_ff [2], st_ff [2];
   logic [IDX_W-1:0] y_i_ff [2], l_i_ff [2];
   logic [IDX_W-1:0] pil_ff, pir_ff;
   logic [CNT_W+1:0] wl_raw, wr_raw;
   logic [IDX_W-1:0] wl_idx, wr_idx;

   assign wl_raw = {2'b00, pil_ff} + (CNT_W+2)'(SPREAD_LOOKAHEAD);
   assign wr_raw = {2'b00, pir_ff} + (CNT_W+2)'(SPREAD_LOOKAHEAD);
   assign wl_idx = (wl_raw >= {2'b00, lcnt_ff}) ? IDX_W'(lcnt_ff - 1'b1) : wl_raw[IDX_W-1:0];
   assign wr_idx = (wr_raw >= {2'b00, rcnt_ff}) ? IDX_W'(rcnt_ff - 1'b1) : wr_raw[IDX_W-1:0];

   // The high neighbour address is held through the step after its read so
   // that it is still on the read register during eval. Likewise the
   // lookahead address is held through d0 so that d1 still sees it.
   always_comb begin
      laddr = idx_ff[IDX_W-1:0];
      raddr = idx_ff[IDX_W-1:0];
      if (cmd.rd_cen) begin
         laddr = lo_idx;
         raddr = lo_idx;
      end else if (cmd.rd_lo || cmd.rd_hi) begin
         laddr = hi_idx;
         raddr = hi_idx;
      end else if (cmd.rd_pair) begin
         laddr = cmd.pair_l ? l_i_ff[0] : y_i_ff[0];
         raddr = cmd.pair_l ? l_i_ff[1] : y_i_ff[1];
      end else if (cmd.rd_look || cmd.d0) begin
         laddr = wl_idx;
         raddr = wr_idx;
      end
   end

   // The center read is launched early: in ST_SC_TEST and at go the
   // address is the next index, which idx_in provides.
   logic [IDX_W-1:0] cen_addr;
   assign cen_addr = idx_in[IDX_W-1:0];

   logic side_done;
   assign side_done = (idx_ff + 1'b1 >= n_cur) || empty_side;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_init) idx_in = '0;
      else if (cmd.scan_next) idx_in = (side_done) ? '0 : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

   // Dedicated center read register, fed at scan_init or scan_next.
   point_type cen_l_ff, cen_r_ff;
   always_ff @(posedge clock) begin
      if (cmd.scan_init || cmd.scan_next) begin
         cen_l_ff <= left_mem[cen_addr];
         cen_r_ff <= right_mem[cen_addr];
      end
   end

   point_type cen_pt;
   logic [14:0] abs_cen;
   assign cen_pt  = cmd.scan_side ? cen_r_ff : cen_l_ff;
   assign abs_cen = cen_pt.a[14] ? 15'(-cen_pt.a) : 15'(cen_pt.a);

   always_ff @(posedge clock) begin
      if (cmd.rd_cen) begin
         a_cen_ff <= abs_cen;
         keep_ff  <= cen_pt.keep;
      end
      if (cmd.rd_lo) a_lo_ff <= abs_rd;
      if (cmd.eval)
         c2_ff <= $signed({2'b00, a_cen_ff, 1'b0}) - $signed({3'b000, a_lo_ff})
                  - $signed({3'b000, abs_rd});
   end

   logic idx_ok_c, idx_ok_s;
   assign idx_ok_c = ({1'b0, idx_ff} < {{(CNT_W-7){1'b0}}, cfg_corner});
   assign idx_ok_s = ({1'b0, idx_ff} < {{(CNT_W-7){1'b0}}, cfg_straight});

   // Side-scan results and pair checks.
   logic [17:0] dx_ff, dy_ff;
   logic [35:0] dx2_ff, dy2_ff;
   logic [36:0] d2_ff, dw2_ff;
   logic [41:0] d25_ff;
   logic [15:0] p2_ff;
   logic        pass_d_ff;
   logic        xl_ok_ff, xr_ok_ff;
   point_type   pl_pt_ff, pr_pt_ff;
   logic        s;

   assign s = cmd.scan_side;

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         for (int k = 0; k < 2; k++) begin
            y_f_ff[k] <= 1'b0;
            l_f_ff[k] <= 1'b0;
            y_i_ff[k] <= '0;
            l_i_ff[k] <= '0;
         end
         st_ff[0] <= ({{(CNT_W-7){1'b0}}, lcnt_ff} > {{(CNT_W-7){1'b0}}, cfg_straight[7:0]});
         st_ff[1] <= ({{(CNT_W-7){1'b0}}, rcnt_ff} > {{(CNT_W-7){1'b0}}, cfg_straight[7:0]});
      end else if (cmd.test && !empty_side && keep_ff) begin
         if (!y_f_ff[s] && c2_ff > TH2_Y_LO && c2_ff < TH2_Y_HI && idx_ok_c) begin
            y_f_ff[s] <= 1'b1;
            y_i_ff[s] <= idx_ff[IDX_W-1:0];
         end
         if (!l_f_ff[s] && c2_ff > TH2_L_LO && c2_ff < TH2_L_HI && idx_ok_c) begin
            l_f_ff[s] <= 1'b1;
            l_i_ff[s] <= idx_ff[IDX_W-1:0];
         end
         if (c2_ff > TH2_BEND && idx_ok_s) st_ff[s] <= 1'b0;
      end else if (cmd.d5 && !(pass_d_ff && 42'(dw2_ff) * 42'd25 > 42'(p2_ff) * 42'd3136
                               && xl_ok_ff && xr_ok_ff)) begin
         if (cmd.pair_l) begin
            l_f_ff[0] <= 1'b0;
            l_f_ff[1] <= 1'b0;
         end else begin
            y_f_ff[0] <= 1'b0;
            y_f_ff[1] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      p2_ff <= 16'(cfg_ppm) * 16'(cfg_ppm);
      if (cmd.rd_pair) begin
         pil_ff   <= cmd.pair_l ? l_i_ff[0] : y_i_ff[0];
         pir_ff   <= cmd.pair_l ? l_i_ff[1] : y_i_ff[1];
      end
      if (cmd.rd_look) begin
         pl_pt_ff <= lrd_ff;
         pr_pt_ff <= rrd_ff;
      end
      if (cmd.d0) begin
         dx_ff <= 18'($signed(pl_pt_ff.x) - $signed(pr_pt_ff.x));
         dy_ff <= 18'($signed(pl_pt_ff.y) - $signed(pr_pt_ff.y));
         xl_ok_ff <= $signed(lrd_ff.x) < $signed(pl_pt_ff.x);
         xr_ok_ff <= $signed(rrd_ff.x) > $signed(pr_pt_ff.x);
      end
      if (cmd.d1) begin
         dx2_ff <= 36'($signed(dx_ff) * $signed(dx_ff));
         dy2_ff <= 36'($signed(dy_ff) * $signed(dy_ff));
         dx_ff  <= 18'($signed(lrd_ff.x) - $signed(rrd_ff.x));
         dy_ff  <= 18'($signed(lrd_ff.y) - $signed(rrd_ff.y));
      end
      if (cmd.d2) begin
         d2_ff  <= {1'b0, dx2_ff} + {1'b0, dy2_ff};
         dx2_ff <= 36'($signed(dx_ff) * $signed(dx_ff));
         dy2_ff <= 36'($signed(dy_ff) * $signed(dy_ff));
      end
      if (cmd.d3) begin
         d25_ff <= 42'(d2_ff) * 42'd25;
         dw2_ff <= {1'b0, dx2_ff} + {1'b0, dy2_ff};
      end
      if (cmd.d4)
         pass_d_ff <= (d25_ff > 42'(p2_ff) * 42'd576) && (d25_ff < 42'(p2_ff) * 42'd2304);
   end

   assign status.scan_last     = empty_side || (idx_ff + 1'b1 >= n_cur);
   assign status.y_pair_needed = y_f_ff[0] && y_f_ff[1];
   assign status.l_pair_needed = cfg_check_l && l_f_ff[0] && l_f_ff[1];

   assign y_left_found   = y_f_ff[0];
   assign y_left_index   = y_f_ff[0] ? 7'(y_i_ff[0]) : 7'd0;
   assign y_right_found  = y_f_ff[1];
   assign y_right_index  = y_f_ff[1] ? 7'(y_i_ff[1]) : 7'd0;
   assign l_left_found   = l_f_ff[0];
   assign l_left_index   = l_f_ff[0] ? 7'(l_i_ff[0]) : 7'd0;
   assign l_right_found  = l_f_ff[1];
   assign l_right_index  = l_f_ff[1] ? 7'(l_i_ff[1]) : 7'd0;
   assign straight_left  = st_ff[0];
   assign straight_right = st_ff[1];

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      (lcnt_ff <= CNT_W'(MAX_POINTS)) && (rcnt_ff <= CNT_W'(MAX_POINTS)))
      else $error("point count beyond store depth");
   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (lcnt_ff == '0 && rcnt_ff == '0))
      else $error("counts not cleared after evaluate");
   a_found_stays: assert property (@(posedge clock) disable iff (reset)
      (cmd.test && y_f_ff[0]) |=> y_f_ff[0])
      else $error("left Y corner lost during scan");

endmodule
`default_nettype wire
